### sv/dcb_pkg.sv
// Shared types, constants and the month table of the day count block.
package dcb_pkg;

    localparam int DATE_W  = 27;
    localparam int YEAR_W  = 14;
    localparam int REM_W   = 14;
    localparam int FIELD_W = 7;
    localparam int DNUM_W  = 24;
    localparam int CALC_W  = 26;
    localparam int COUNT_W = 23;
    localparam int BASIS_W = 9;

    localparam logic [DATE_W-1:0] RECIP_10K   = 27'd109951162;
    localparam int                SHIFT_10K   = 40;
    localparam logic [12:0]       RECIP_100   = 13'd5243;
    localparam int                SHIFT_100   = 19;
    localparam logic [YEAR_W-1:0] TEN_K       = 14'd10000;

    localparam logic [1:0] MODE_THIRTY_360 = 2'd0;
    localparam logic [1:0] MODE_ACT_360    = 2'd1;
    localparam logic [1:0] MODE_ACT_365    = 2'd2;
    localparam logic [1:0] MODE_ACT_ACT    = 2'd3;
    localparam logic [1:0] MODE_RESET      = MODE_ACT_ACT;

    localparam logic [BASIS_W-1:0] BASIS_360 = 9'd360;
    localparam logic [BASIS_W-1:0] BASIS_365 = 9'd365;

    localparam logic signed [CALC_W-1:0] COUNT_MAX = 26'sd4194303;
    localparam logic signed [CALC_W-1:0] COUNT_MIN = -26'sd4194304;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [DNUM_W-1:0]  day_num;
        logic               bad;
    } dcb_date_t;

    function automatic logic [8:0] month_start(input logic [FIELD_W-1:0] m);
        logic [8:0] res;
        unique case (m)
            7'd2:    res = 9'd31;
            7'd3:    res = 9'd59;
            7'd4:    res = 9'd90;
            7'd5:    res = 9'd120;
            7'd6:    res = 9'd151;
            7'd7:    res = 9'd181;
            7'd8:    res = 9'd212;
            7'd9:    res = 9'd243;
            7'd10:   res = 9'd273;
            7'd11:   res = 9'd304;
            7'd12:   res = 9'd334;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

### sv/dcb_date_unit.sv
// Five-stage pipeline that splits one yyyymmdd date and forms its day number.
module dcb_date_unit
    import dcb_pkg::*;
#(
    parameter int BASE_YEAR = 1900
) (
    input  logic              aclk,
    input  logic [5:1]        stage_en,
    input  logic [DATE_W-1:0] date_in,
    output dcb_date_t         date_out
);

    localparam int BASE_M1    = BASE_YEAR - 1;
    localparam int LEAPS_BASE = BASE_M1 / 4 - BASE_M1 / 100 + BASE_M1 / 400;
    localparam logic [YEAR_W-1:0] BASE_Y = YEAR_W'(BASE_YEAR);
    localparam logic [DNUM_W-1:0] LEAPS_B = DNUM_W'(LEAPS_BASE);

    // Stage 1: estimate of the year by reciprocal multiplication.
    logic [DATE_W-1:0]   s1_date_reg;
    logic [YEAR_W-1:0]   s1_q_reg;
    logic [2*DATE_W-1:0] s1_prod;

    assign s1_prod = {{DATE_W{1'b0}}, date_in} * {{DATE_W{1'b0}}, RECIP_10K};

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            s1_date_reg <= date_in;
            s1_q_reg    <= s1_prod[SHIFT_10K +: YEAR_W];
        end
    end

    // Stage 2: correct the estimate and keep the month and day remainder.
    logic [YEAR_W-1:0] s2_year_reg;
    logic [REM_W-1:0]  s2_rem_reg;
    logic [DATE_W-1:0] s2_back;
    logic [REM_W:0]    s2_rem;

    assign s2_back = DATE_W'(s1_q_reg) * DATE_W'(TEN_K);
    assign s2_rem  = (REM_W+1)'(s1_date_reg - s2_back);

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            if (s2_rem >= {1'b0, TEN_K}) begin
                s2_year_reg <= s1_q_reg + 1'b1;
                s2_rem_reg  <= REM_W'(s2_rem - {1'b0, TEN_K});
            end else begin
                s2_year_reg <= s1_q_reg;
                s2_rem_reg  <= s2_rem[REM_W-1:0];
            end
        end
    end

    // Stage 3: month and the hundreds of the year and of the year before.
    logic [YEAR_W-1:0]  s3_year_reg;
    logic [REM_W-1:0]   s3_rem_reg;
    logic [FIELD_W-1:0] s3_month_reg;
    logic [7:0]         s3_qy_reg;
    logic [7:0]         s3_qp_reg;
    logic [YEAR_W-1:0]  s3_prev_reg;
    logic [YEAR_W-1:0]  s3_prev;
    logic [26:0]        s3_mprod;
    logic [26:0]        s3_yprod;
    logic [26:0]        s3_pprod;

    assign s3_prev  = s2_year_reg - 1'b1;
    assign s3_mprod = 27'(s2_rem_reg) * 27'(RECIP_100);
    assign s3_yprod = 27'(s2_year_reg) * 27'(RECIP_100);
    assign s3_pprod = 27'(s3_prev) * 27'(RECIP_100);

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            s3_year_reg  <= s2_year_reg;
            s3_rem_reg   <= s2_rem_reg;
            s3_prev_reg  <= s3_prev;
            s3_month_reg <= s3_mprod[SHIFT_100 +: FIELD_W];
            s3_qy_reg    <= s3_yprod[SHIFT_100 +: 8];
            s3_qp_reg    <= s3_pprod[SHIFT_100 +: 8];
        end
    end

    // Stage 4: day, leap years before this year, leap flag and field check.
    logic [YEAR_W-1:0]  s4_year_reg;
    logic [FIELD_W-1:0] s4_month_reg;
    logic [FIELD_W-1:0] s4_day_reg;
    logic [YEAR_W-1:0]  s4_leaps_reg;
    logic               s4_leap_reg;
    logic               s4_bad_reg;
    logic [REM_W-1:0]   s4_day_wide;
    logic [FIELD_W-1:0] s4_day;
    logic [YEAR_W-1:0]  s4_leaps;
    logic               s4_cent;
    logic               s4_leap;

    assign s4_day_wide = s3_rem_reg - REM_W'(s3_month_reg) * REM_W'(100);
    assign s4_day      = s4_day_wide[FIELD_W-1:0];
    assign s4_leaps    = (s3_prev_reg >> 2) - YEAR_W'(s3_qp_reg) + YEAR_W'(s3_qp_reg >> 2);
    assign s4_cent     = (s3_year_reg == YEAR_W'(s3_qy_reg) * YEAR_W'(100));
    assign s4_leap     = (s3_year_reg[1:0] == 2'd0) && (!s4_cent || s3_qy_reg[1:0] == 2'd0);

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            s4_year_reg  <= s3_year_reg;
            s4_month_reg <= s3_month_reg;
            s4_day_reg   <= s4_day;
            s4_leaps_reg <= s4_leaps;
            s4_leap_reg  <= s4_leap;
            s4_bad_reg   <= (s3_month_reg < 7'd1) || (s3_month_reg > 7'd12) ||
                            (s4_day < 7'd1) || (s4_day > 7'd31);
        end
    end

    // Stage 5: day number counted from the first of January of the base year.
    logic [DNUM_W-1:0] s5_years;
    logic [DNUM_W-1:0] s5_num;
    logic              s5_after;
    logic              s5_extra;

    assign s5_after = (s4_year_reg > BASE_Y);
    assign s5_years = s5_after ?
                      DNUM_W'(s4_year_reg - BASE_Y) * DNUM_W'(365) +
                      DNUM_W'(s4_leaps_reg) - LEAPS_B : '0;
    assign s5_extra = (s4_month_reg > 7'd2) && s4_leap_reg;
    assign s5_num   = s5_years + DNUM_W'(month_start(s4_month_reg)) +
                      DNUM_W'(s5_extra) + DNUM_W'(s4_day_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            date_out.year    <= s4_year_reg;
            date_out.month   <= s4_month_reg;
            date_out.day     <= s4_day_reg;
            date_out.day_num <= s5_num;
            date_out.bad     <= s4_bad_reg;
        end
    end

endmodule

### sv/day_count_between_dates.sv
// Top level of the day count block: stream channels, register port and final stages.
// Usage:
// Each input beat on the s_ channel carries a start date and an end date, each as a
// decimal yyyymmdd number. One result beat per input beat leaves on the m_ channel in
// the same order: the signed day count from start to end, the year basis (360 or 365)
// and an error flag that is set, with a count of zero, when a month or day is invalid.
// The convention is chosen by the register at byte address 0 of the APB port: 0 is
// thirty/360, 1 actual/360, 2 actual/365 and 3 simplified actual/actual. It should be
// written only while no beats are in flight.
// The block accepts one beat every cycle while the receiver keeps m_tready high; the
// seven register stages of the date split, day number and count pipeline hold the
// beats in flight. A count beyond the 23-bit signed range saturates.
// Reset clears all stage valid bits and returns the convention to actual/actual.
// When the receiver holds m_tready low, the result stays on m_tdata and beats behind
// it close up into empty stages; s_tready falls only once every stage is full.
module day_count_between_dates
    import dcb_pkg::*;
#(
    parameter int BASE_YEAR = 1900
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // start_date [26:0], end_date [53:27], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // day_count [22:0], year_basis [31:23],
                                   // date_error [32], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0] mode_reg;

    assign pready = 1'b1;
    assign prdata = {30'd0, mode_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            mode_reg <= pwdata[1:0];
        end
    end

    logic [7:1] v_reg;
    logic [7:1] rdy;

    always_comb begin
        rdy[7] = !v_reg[7] || m_tready;
        for (int k = 6; k >= 1; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[1];
    assign m_tvalid = v_reg[7];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[1]) begin
                v_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= 7; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    dcb_date_t start_info;
    dcb_date_t end_info;

    dcb_date_unit #(.BASE_YEAR(BASE_YEAR)) u_start (
        .aclk     (aclk),
        .stage_en (rdy[5:1]),
        .date_in  (s_tdata[26:0]),
        .date_out (start_info)
    );

    dcb_date_unit #(.BASE_YEAR(BASE_YEAR)) u_end (
        .aclk     (aclk),
        .stage_en (rdy[5:1]),
        .date_in  (s_tdata[53:27]),
        .date_out (end_info)
    );

    // Stage 6: both candidate counts.
    logic signed [CALC_W-1:0] thirty_reg;
    logic signed [CALC_W-1:0] actual_reg;
    logic                     bad_reg;
    logic [FIELD_W-1:0]       d1_adj;
    logic [FIELD_W-1:0]       d2_adj;
    logic signed [CALC_W-1:0] y_diff;
    logic signed [CALC_W-1:0] m_diff;
    logic signed [CALC_W-1:0] d_diff;

    assign d1_adj = (start_info.day == 7'd31) ? 7'd30 : start_info.day;
    assign d2_adj = (end_info.day == 7'd31 && d1_adj >= 7'd30) ? 7'd30 : end_info.day;
    assign y_diff = $signed({12'd0, end_info.year}) - $signed({12'd0, start_info.year});
    assign m_diff = $signed({19'd0, end_info.month}) - $signed({19'd0, start_info.month});
    assign d_diff = $signed({19'd0, d2_adj}) - $signed({19'd0, d1_adj});

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            thirty_reg <= y_diff * 26'sd360 + m_diff * 26'sd30 + d_diff;
            actual_reg <= $signed({2'd0, end_info.day_num}) -
                          $signed({2'd0, start_info.day_num});
            bad_reg    <= start_info.bad || end_info.bad;
        end
    end

    // Stage 7: convention select, saturation and the output register.
    logic [COUNT_W-1:0]       count_reg;
    logic [BASIS_W-1:0]       basis_reg;
    logic                     err_reg;
    logic signed [CALC_W-1:0] raw;
    logic signed [CALC_W-1:0] clamped;

    assign raw = (mode_reg == MODE_THIRTY_360) ? thirty_reg : actual_reg;

    always_comb begin
        priority if (raw > COUNT_MAX) begin
            clamped = COUNT_MAX;
        end else if (raw < COUNT_MIN) begin
            clamped = COUNT_MIN;
        end else begin
            clamped = raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[7]) begin
            count_reg <= bad_reg ? '0 : clamped[COUNT_W-1:0];
            basis_reg <= (mode_reg == MODE_THIRTY_360 || mode_reg == MODE_ACT_360) ?
                         BASIS_360 : BASIS_365;
            err_reg   <= bad_reg;
        end
    end

    assign m_tdata = {7'd0, err_reg, basis_reg, count_reg};

`ifndef ASSERT_OFF
    a_error_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && err_reg |-> count_reg == '0)
        else $error("error beat carries a non-zero count");

    a_basis_legal : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> basis_reg == BASIS_360 || basis_reg == BASIS_365)
        else $error("year basis is neither 360 nor 365");

    a_accept_fills : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v_reg[1])
        else $error("accepted beat did not reach the first stage");

    a_empty_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        !v_reg[1] |-> s_tready)
        else $error("first stage empty but input not ready");
`endif

endmodule
